/* hw/rtl/dcr_pkg.sv */
// shared constants for the distance constraint relaxation block
package dcr_pkg;
  // byte address of the rest length register
  localparam logic [1:0] REST_ADDR = 2'd0;
  // rest length after reset, in whole units
  localparam int unsigned REST_INT = 100;
endpackage

/* hw/rtl/dcr_in_if.sv */
// input channel: positions of two particles
interface dcr_in_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_x;
  logic signed [COORD_WIDTH-1:0] first_y;
  logic signed [COORD_WIDTH-1:0] second_x;
  logic signed [COORD_WIDTH-1:0] second_y;
  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

/* hw/rtl/dcr_out_if.sv */
// result channel: corrected positions and coincident flag
interface dcr_out_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_first_x;
  logic signed [COORD_WIDTH-1:0] new_first_y;
  logic signed [COORD_WIDTH-1:0] new_second_x;
  logic signed [COORD_WIDTH-1:0] new_second_y;
  logic                          coincident;
  modport source (output valid, new_first_x, new_first_y, new_second_x, new_second_y,
                  coincident, input ready);
  modport sink (input valid, new_first_x, new_first_y, new_second_x, new_second_y,
                coincident, output ready);
endinterface

/* hw/rtl/dcr_sqrt_cell.sv */
// one restoring square root step: one root bit per cell
module dcr_sqrt_cell #(
  parameter int RW = 25
) (
  input  logic            clk,
  input  logic            en,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW+1:0]   rem_r,
  output logic [RW-1:0]   root_r,
  output logic [2*RW-1:0] rad_r
);
  logic [RW+1:0] t;
  logic [RW+1:0] trial;
  logic          ge;

  always_comb begin
    t     = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? (t - trial) : t;
      root_r <= {root_i[RW-2:0], ge};
      rad_r  <= {rad_i[2*RW-3:0], 2'b00};
    end
  end
endmodule

/* hw/rtl/dcr_div_cell.sv */
// one restoring division step for the x and y lanes, shared divisor
module dcr_div_cell #(
  parameter int DW = 26,
  parameter int QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dvs_i,
  input  logic [DW-1:0] rem_x_i,
  input  logic [QW-1:0] num_x_i,
  input  logic [DW-1:0] rem_y_i,
  input  logic [QW-1:0] num_y_i,
  output logic [DW-1:0] dvs_r,
  output logic [DW-1:0] rem_x_r,
  output logic [QW-1:0] num_x_r,
  output logic [DW-1:0] rem_y_r,
  output logic [QW-1:0] num_y_r
);
  logic [DW:0] tx, ty, dd, sx, sy;
  logic        gx, gy;

  always_comb begin
    tx = {rem_x_i, num_x_i[QW-1]};
    ty = {rem_y_i, num_y_i[QW-1]};
    dd = {1'b0, dvs_i};
    gx = (tx >= dd);
    gy = (ty >= dd);
    sx = gx ? (tx - dd) : tx;
    sy = gy ? (ty - dd) : ty;
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r   <= dvs_i;
      rem_x_r <= sx[DW-1:0];
      rem_y_r <= sy[DW-1:0];
      num_x_r <= {num_x_i[QW-2:0], gx};
      num_y_r <= {num_y_i[QW-2:0], gy};
    end
  end
endmodule

/* hw/rtl/distance_constraint_relax.sv */
// top level: pipelined distance constraint projection for a particle pair
// Usage:
//   in_ch carries one particle pair per word (valid/ready), out_ch one
//   corrected pair per word with the coincident flag; the user must set rest
//   length over the cfg_ port at byte address 0 while the block is idle (not enforced).
// Throughput: one word per cycle, sustained while out_ch is not stalled. The datapath is a row of
//   cells that all advance together: two front stages (difference, squares),
//   COORD_WIDTH+1 square root cells, one correction product stage,
//   COORD_WIDTH+1 division cells and the output register.
// The difference stage loads at the accepting edge; the root and quotient
//   chains produce one bit per cell.
// Reset: the pipeline empties, out_ch.valid drops, rest length returns to
//   100.0 in the coordinate format.
// Stall: while out_ch.valid is high and out_ch.ready low the whole row of
//   cells holds, and in_ch.ready is low; a word in the output register is
//   never lost and a new word enters in the same cycle the old one leaves.
module distance_constraint_relax #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  dcr_in_if.sink              in_ch,
  dcr_out_if.source           out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import dcr_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int R   = W + 1;
  localparam int DW  = W + 2;
  localparam int QW  = W + 1;
  localparam int NW  = 2 * W + 2;
  localparam int NST = R + QW + 3;
  localparam int EI  = R + 2;
  localparam logic [W-2:0] REST_RST = (W-1)'(longint'(REST_INT) << FRAC_BITS);

  typedef struct packed {
    logic [W-1:0] x1;
    logic [W-1:0] y1;
    logic [W-1:0] x2;
    logic [W-1:0] y2;
    logic [W:0]   adx;
    logic [W:0]   ady;
    logic         nx;
    logic         ny;
    logic         sx;
    logic         sy;
    logic         z;
  } pass_t;

  logic [W-2:0] rest_r;
  logic         adv;
  logic         out_valid_r;
  logic [NST-1:0] vld_r;
  pass_t          pl_r [NST];

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REST_ADDR) ? 32'(rest_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REST_ADDR) begin
      rest_r <= cfg_pwdata[W-2:0];
    end
  end

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // front stage: differences and magnitudes
  logic [W:0] dx, dy;
  pass_t      a_nxt;
  always_comb begin
    dx = {in_ch.second_x[W-1], in_ch.second_x} - {in_ch.first_x[W-1], in_ch.first_x};
    dy = {in_ch.second_y[W-1], in_ch.second_y} - {in_ch.first_y[W-1], in_ch.first_y};
    a_nxt     = '0;
    a_nxt.x1  = in_ch.first_x;
    a_nxt.y1  = in_ch.first_y;
    a_nxt.x2  = in_ch.second_x;
    a_nxt.y2  = in_ch.second_y;
    a_nxt.nx  = dx[W];
    a_nxt.ny  = dy[W];
    a_nxt.adx = dx[W] ? (~dx + 1'b1) : dx;
    a_nxt.ady = dy[W] ? (~dy + 1'b1) : dy;
    a_nxt.z   = (dx == '0) && (dy == '0);
  end

  // square root chain wires, index 0 is the squared distance
  logic [R+1:0]   sq_rem  [R+1];
  logic [R-1:0]   sq_root [R+1];
  logic [2*R-1:0] sq_rad  [R+1];
  logic [2*R-1:0] ssq_r;

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = ssq_r;

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    dcr_sqrt_cell #(.RW(R)) u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_r  (sq_rem[k+1]),
      .root_r (sq_root[k+1]),
      .rad_r  (sq_rad[k+1])
    );
  end

  // correction product stage
  logic [R-1:0]    dist_w;
  logic [W+1:0]    e;
  logic [W:0]      ae;
  logic [NW-1:0]   px, py;
  logic [NW-1:0]   nx_r, ny_r;
  logic [DW-1:0]   dvs_r;

  always_comb begin
    dist_w = sq_root[R];
    e      = {1'b0, dist_w} - {3'b000, rest_r};
    ae     = e[W+1] ? (~e[W:0] + 1'b1) : e[W:0];
    px     = NW'(pl_r[EI-1].adx * ae) + NW'(dist_w);
    py     = NW'(pl_r[EI-1].ady * ae) + NW'(dist_w);
  end

  // offset signs join the payload at the product stage
  pass_t e_nxt;
  always_comb begin
    e_nxt    = pl_r[EI-1];
    e_nxt.sx = pl_r[EI-1].nx ^ e[W+1];
    e_nxt.sy = pl_r[EI-1].ny ^ e[W+1];
  end

  logic [DW-1:0] dv_dvs [QW+1];
  logic [DW-1:0] dv_rx  [QW+1];
  logic [QW-1:0] dv_nx  [QW+1];
  logic [DW-1:0] dv_ry  [QW+1];
  logic [QW-1:0] dv_ny  [QW+1];

  assign dv_dvs[0] = dvs_r;
  assign dv_rx[0]  = DW'(nx_r[NW-1:QW]);
  assign dv_nx[0]  = nx_r[QW-1:0];
  assign dv_ry[0]  = DW'(ny_r[NW-1:QW]);
  assign dv_ny[0]  = ny_r[QW-1:0];

  for (genvar k = 0; k < QW; k++) begin : g_div
    dcr_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .dvs_i   (dv_dvs[k]),
      .rem_x_i (dv_rx[k]),
      .num_x_i (dv_nx[k]),
      .rem_y_i (dv_ry[k]),
      .num_y_i (dv_ny[k]),
      .dvs_r   (dv_dvs[k+1]),
      .rem_x_r (dv_rx[k+1]),
      .num_x_r (dv_nx[k+1]),
      .rem_y_r (dv_ry[k+1]),
      .num_y_r (dv_ny[k+1])
    );
  end

  // payload registers alongside the cells
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= a_nxt;
      for (int k = 1; k < NST; k++) begin
        pl_r[k] <= (k == EI) ? e_nxt : pl_r[k-1];
      end
      ssq_r <= (2*R)'(pl_r[0].adx * pl_r[0].adx) + (2*R)'(pl_r[0].ady * pl_r[0].ady);
      nx_r  <= px;
      ny_r  <= py;
      dvs_r <= {dist_w, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // output stage: apply offsets and saturate, or pass coincident pairs unchanged
  function automatic logic [W-1:0] sat(input logic [W+2:0] v);
    logic [W+2:0] hi, lo;
    hi = (W+3)'((longint'(1) << (W-1)) - 1);
    lo = ~hi;
    if ($signed(v) > $signed(hi)) begin
      return hi[W-1:0];
    end else if ($signed(v) < $signed(lo)) begin
      return lo[W-1:0];
    end
    return v[W-1:0];
  endfunction

  pass_t         lp;
  logic [W+2:0]  ox, oy;
  logic [W+2:0]  ex1, ey1, ex2, ey2;
  always_comb begin
    lp  = pl_r[NST-1];
    ox  = lp.sx ? (~{2'b00, dv_nx[QW]} + 1'b1) : {2'b00, dv_nx[QW]};
    oy  = lp.sy ? (~{2'b00, dv_ny[QW]} + 1'b1) : {2'b00, dv_ny[QW]};
    ex1 = {{3{lp.x1[W-1]}}, lp.x1};
    ey1 = {{3{lp.y1[W-1]}}, lp.y1};
    ex2 = {{3{lp.x2[W-1]}}, lp.x2};
    ey2 = {{3{lp.y2[W-1]}}, lp.y2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.coincident <= lp.z;
      if (lp.z) begin
        out_ch.new_first_x  <= lp.x1;
        out_ch.new_first_y  <= lp.y1;
        out_ch.new_second_x <= lp.x2;
        out_ch.new_second_y <= lp.y2;
      end else begin
        out_ch.new_first_x  <= sat(ex1 + ox);
        out_ch.new_first_y  <= sat(ey1 + oy);
        out_ch.new_second_x <= sat(ex2 - ox);
        out_ch.new_second_y <= sat(ey2 - oy);
      end
    end
  end

  assign out_ch.valid = out_valid_r;
endmodule

/* hw/rtl/dcr_checker.sv */
// port-level checks for the distance constraint block, with bind
module dcr_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] nfx,
  input logic [COORD_WIDTH-1:0] nfy,
  input logic [COORD_WIDTH-1:0] nsx,
  input logic [COORD_WIDTH-1:0] nsy,
  input logic                   coinc,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [1:0]             paddr,
  input logic [31:0]            pwdata,
  input logic [31:0]            prdata
);
  import dcr_pkg::*;

  localparam logic [31:0] MASK = 32'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped under stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_coinc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && coinc |-> (nfx == nsx) && (nfy == nsy))
    else $error("coincident result with distinct positions");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && paddr == REST_ADDR
    |=> paddr != REST_ADDR || prdata == ($past(pwdata) & MASK))
    else $error("rest length readback mismatch");
endmodule

bind distance_constraint_relax dcr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_dcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .nfx       (out_ch.new_first_x),
  .nfy       (out_ch.new_first_y),
  .nsx       (out_ch.new_second_x),
  .nsy       (out_ch.new_second_y),
  .coinc     (out_ch.coincident),
  .psel      (cfg_psel),
  .penable   (cfg_penable),
  .pwrite    (cfg_pwrite),
  .paddr     (cfg_paddr),
  .pwdata    (cfg_pwdata),
  .prdata    (cfg_prdata)
);

/* sim/tb_distance_constraint_relax.sv */
// testbench for the distance constraint relaxation block: random and directed pairs
module tb_distance_constraint_relax;
  timeunit 1ns;
  timeprecision 1ps;
  import dcr_pkg::*;

  localparam int CW = 24;
  localparam int LATENCY = 2*CW+5;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy, sx, sy;
  } pair_t;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy, sx, sy;
    logic coinc;
  } moved_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  dcr_in_if #(.COORD_WIDTH(CW)) in_ch();
  dcr_out_if #(.COORD_WIDTH(CW)) out_ch();

  distance_constraint_relax #(.COORD_WIDTH(CW), .FRAC_BITS(8)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [CW-2:0] rest_len;
  moved_t moved_q[$];
  int errors = 0;
  int checked = 0;
  int send_idle = 0;
  int stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // floor square root, exact for values below 2^52
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned lo, hi, m;
    lo = 0;
    hi = 64'd1 << 27;
    while (hi - lo > 1) begin
      m = lo + ((hi - lo) >> 1);
      if (m * m <= v) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  // delta * err / (2*dn), magnitude rounded half away from zero
  function automatic longint shift_of(longint dl, longint err, longint unsigned dn);
    logic [127:0] num;
    logic [127:0] q;
    longint unsigned ad, ae;
    ad = dl < 0 ? -dl : dl;
    ae = err < 0 ? -err : err;
    num = 128'(ad) * 128'(ae) + 128'(dn);
    q = num / (128'(dn) << 1);
    return ((dl < 0) != (err < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [CW-1:0] clamp(longint v);
    longint maxv, minv;
    maxv = (longint'(1) << (CW-1)) - 1;
    minv = -maxv - 1;
    if (v > maxv) v = maxv;
    if (v < minv) v = minv;
    return v[CW-1:0];
  endfunction

  function automatic moved_t project_pair(pair_t p);
    moved_t r;
    longint x1, y1, x2, y2, dx, dy, e, ox, oy;
    longint unsigned sq, d;
    x1 = p.fx; y1 = p.fy; x2 = p.sx; y2 = p.sy;
    dx = x2 - x1;
    dy = y2 - y1;
    sq = longint'(dx * dx) + longint'(dy * dy);
    if (sq == 0) begin
      r.fx = p.fx; r.fy = p.fy; r.sx = p.sx; r.sy = p.sy;
      r.coinc = 1;
      return r;
    end
    d = root_floor(sq);
    e = longint'(d) - longint'(rest_len);
    ox = shift_of(dx, e, d);
    oy = shift_of(dy, e, d);
    r.fx = clamp(x1 + ox);
    r.fy = clamp(y1 + oy);
    r.sx = clamp(x2 - ox);
    r.sy = clamp(y2 - oy);
    r.coinc = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // result side: random stall and field checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (moved_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          moved_t w;
          w = moved_q.pop_front();
          checked++;
          if (out_ch.new_first_x !== w.fx)
            report_mismatch("new_first_x", out_ch.new_first_x, w.fx);
          if (out_ch.new_first_y !== w.fy)
            report_mismatch("new_first_y", out_ch.new_first_y, w.fy);
          if (out_ch.new_second_x !== w.sx)
            report_mismatch("new_second_x", out_ch.new_second_x, w.sx);
          if (out_ch.new_second_y !== w.sy)
            report_mismatch("new_second_y", out_ch.new_second_y, w.sy);
          if (out_ch.coincident !== w.coinc)
            report_mismatch("coincident", out_ch.coincident, w.coinc);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end else begin
      out_ch.ready <= 0;
    end
  end

  // valid stays high from one word to the next unless the sender idles
  task automatic send_pair(pair_t p);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.first_x <= p.fx;
    in_ch.first_y <= p.fy;
    in_ch.second_x <= p.sx;
    in_ch.second_y <= p.sy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    moved_q = {moved_q, project_pair(p)};
  endtask

  task automatic drain;
    in_ch.valid <= 0;
    while (moved_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_rest(logic [31:0] v);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= REST_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    rest_len = v[CW-2:0];
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int unsigned k;
    k = $urandom_range(9);
    p.fx = CW'($urandom);
    p.fy = CW'($urandom);
    p.sx = CW'($urandom);
    p.sy = CW'($urandom);
    if (k < 5) begin
      // nearby particles around a random center, realistic chain geometry
      logic signed [CW-1:0] c;
      c = CW'($urandom);
      p.fx = c;
      p.fy = c ^ CW'($urandom_range(65535));
      p.sx = p.fx + CW'($signed(CW'($urandom_range(131071))) - 65536);
      p.sy = p.fy + CW'($signed(CW'($urandom_range(131071))) - 65536);
    end else if (k == 5) begin
      p.sx = p.fx;
      p.sy = p.fy;
    end
    return p;
  endfunction

  task automatic test_directed;
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_pair('{0, 0, 0, 0});
    send_pair('{mx, mx, mx, mx});
    send_pair('{mn, mn, mx, mx});
    send_pair('{mx, mx, mn, mn});
    send_pair('{mn, mx, mx, mn});
    send_pair('{0, 0, CW'(256*100), 0});
    send_pair('{0, 0, CW'(256*50), 0});
    send_pair('{0, 0, CW'(1), 0});
    send_pair('{0, 0, 0, CW'(-1)});
    send_pair('{0, 0, CW'(768), CW'(1024)});
    send_pair('{mn, 0, CW'(mn + 1), 0});
    send_pair('{mx, mn, mx, CW'(mn + 25600)});
    send_pair('{CW'(-5), CW'(7), CW'(-5), CW'(7)});
    send_pair('{CW'(100), CW'(200), CW'(-300), CW'(400)});
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle = idle;
    stall_pct = stall;
    repeat (n) send_pair(rand_pair());
    drain();
  endtask

  task automatic test_rest_extremes;
    write_rest(32'd0);
    test_random(60, 0, 0);
    write_rest(32'h007F_FFFF);
    test_random(60, 31, 31);
    write_rest(32'hFF80_0001);
    test_random(60, 0, 0);
    write_rest($urandom);
    test_random(60, 49, 0);
    write_rest(32'd25600);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    rest_len = (CW-1)'(REST_INT * 256);
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_rest_extremes();
    test_random(200, 0, 0);
    test_random(200, 49, 0);
    test_random(200, 0, 49);
    test_random(200, 31, 31);
    $display("checked %0d corrected pairs over directed cases, rest length extremes", checked);
    $display("and random pairs with and without source gaps and sink stalls");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/dcr_pkg.sv
hw/rtl/dcr_in_if.sv
hw/rtl/dcr_out_if.sv
hw/rtl/dcr_sqrt_cell.sv
hw/rtl/dcr_div_cell.sv
hw/rtl/distance_constraint_relax.sv
hw/rtl/dcr_checker.sv
sim/tb_distance_constraint_relax.sv
